// File: design/svpd_pkg.sv
// Shared types, constants and the sign-code to sector map for the SVPWM duty core.
package svpd_pkg;

   localparam int ALPHA_W = 16;
   localparam int DUTY_W = 16;
   localparam int SECTOR_W = 3;
   localparam int PROD_W = 34;   // 18-bit signed constant times 16-bit signed input
   localparam int PROJ_W = 19;   // projections in half-LSB units
   localparam int TIME_W = 18;   // one active time, magnitude only
   localparam int ZERO_W = 17;   // zero time, 0 to full scale
   localparam int ACT_W = 19;    // sum of two active times

   localparam logic signed [17:0] COS30_Q16 = 18'sd56756;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 34'sd16384;
   localparam logic signed [ACT_W+1:0] FULL_SCALE = 21'sd65536;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 16'd32768;

   localparam logic [SECTOR_W-1:0] SECTOR_NONE = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;
   localparam logic [SECTOR_W-1:0] SECTOR_6 = 3'd6;

   typedef struct packed {
      logic signed [ALPHA_W-1:0] alpha;
      logic signed [ALPHA_W-1:0] beta;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      logic [DUTY_W-1:0] duty_c;
      logic [SECTOR_W-1:0] sector_number;
   } rsp_type;

   typedef struct packed {
      logic signed [PROJ_W-1:0] p1;
      logic signed [PROJ_W-1:0] p2;
      logic signed [PROJ_W-1:0] p3;
      logic [SECTOR_W-1:0] sector;
   } proj_type;

   typedef struct packed {
      logic [ZERO_W-1:0] t0;
      logic [ACT_W-1:0] act_a;
      logic [ACT_W-1:0] act_b;
      logic [ACT_W-1:0] act_c;
      logic [SECTOR_W-1:0] sector;
   } time_type;

   // Bit 0: P1 > 0, bit 1: P2 > 0, bit 2: P3 > 0.
   function automatic logic [SECTOR_W-1:0] code_to_sector(input logic [2:0] code);
      logic [SECTOR_W-1:0] sec;
      unique case (code)
         3'd3: sec = SECTOR_1;
         3'd1: sec = SECTOR_2;
         3'd5: sec = SECTOR_3;
         3'd4: sec = SECTOR_4;
         3'd6: sec = SECTOR_5;
         3'd2: sec = SECTOR_6;
         default: sec = SECTOR_NONE;
      endcase
      return sec;
   endfunction

endpackage

// File: design/space_vector_pwm_duty_core.sv
// Top level of the space vector PWM duty core.
//
//   channel   ports                        handshake
//   request   start, busy, req_word        word taken when start is high and busy low
//   response  rsp_valid, rsp_word          word shown for one cycle, no back-pressure
//
// One word enters every cycle; busy is always low since nothing is ever held.
// Four register stages (multiplier, projections, times, duties) lie in that order
// between an accepted word and its result on rsp_*.
// Reset clears only the stage valid bits; the data registers keep their contents.
module space_vector_pwm_duty_core import svpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   logic     accept;
   logic     proj_valid;
   proj_type proj_word;
   logic     time_valid;
   time_type time_word;

   assign busy = 1'b0;
   assign accept = start && !busy;

   svpd_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (req_word),
      .out_valid (proj_valid),
      .out_word  (proj_word)
   );

   svpd_time u_time (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .in_word   (proj_word),
      .out_valid (time_valid),
      .out_word  (time_word)
   );

   svpd_duty u_duty (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (time_valid),
      .in_word   (time_word),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule

// File: design/svpd_proj.sv
// Stages one and two: cos30 scaling of alpha, then projections and sector.
module svpd_proj import svpd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_word,
   output logic     out_valid,
   output proj_type out_word
);

   logic                       mul_valid_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [ALPHA_W-1:0]  beta_ff;
   logic                       proj_valid_ff;
   proj_type                   proj_ff;
   proj_type                   proj_in;
   logic signed [PROD_W-1:0]   rounded;
   logic signed [PROJ_W-1:0]   c_val;
   logic signed [PROJ_W-1:0]   beta_ext;
   logic [2:0]                 code;

   assign prod_in = PROD_W'(COS30_Q16 * in_word.alpha);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         proj_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         proj_valid_ff <= mul_valid_ff;
      end
      prod_ff <= prod_in;
      beta_ff <= in_word.beta;
      proj_ff <= proj_in;
   end

   always_comb begin
      // The top bits of the rounded product are the floor of the divide by 2^15.
      rounded = prod_ff + ROUND_HALF;
      c_val = rounded[PROD_W-1:15];
      beta_ext = PROJ_W'(beta_ff);
      proj_in.p1 = {{(PROJ_W-ALPHA_W-1){beta_ff[ALPHA_W-1]}}, beta_ff, 1'b0};
      proj_in.p2 = c_val - beta_ext;
      proj_in.p3 = -c_val - beta_ext;
      code[0] = !proj_in.p1[PROJ_W-1] && (|proj_in.p1);
      code[1] = !proj_in.p2[PROJ_W-1] && (|proj_in.p2);
      code[2] = !proj_in.p3[PROJ_W-1] && (|proj_in.p3);
      proj_in.sector = code_to_sector(code);
   end

   assign out_valid = proj_valid_ff;
   assign out_word = proj_ff;

endmodule

// File: design/svpd_time.sv
// Stage three: active times, zero time and per-phase active sums.
module svpd_time import svpd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  proj_type in_word,
   output logic     out_valid,
   output time_type out_word
);

   logic                      valid_ff;
   time_type                  time_ff;
   time_type                  time_in;
   logic signed [PROJ_W-1:0]  t1_s;
   logic signed [PROJ_W-1:0]  t2_s;
   logic [TIME_W-1:0]         t1;
   logic [TIME_W-1:0]         t2;
   logic [ACT_W-1:0]          both;
   logic signed [ACT_W+1:0]   diff;

   always_comb begin
      t1_s = '0;
      t2_s = '0;
      unique case (in_word.sector)
         SECTOR_1: begin t1_s = in_word.p2;  t2_s = in_word.p1;  end
         SECTOR_2: begin t1_s = -in_word.p3; t2_s = -in_word.p2; end
         SECTOR_3: begin t1_s = in_word.p1;  t2_s = in_word.p3;  end
         SECTOR_4: begin t1_s = -in_word.p2; t2_s = -in_word.p1; end
         SECTOR_5: begin t1_s = in_word.p3;  t2_s = in_word.p2;  end
         SECTOR_6: begin t1_s = -in_word.p1; t2_s = -in_word.p3; end
         default: begin t1_s = '0; t2_s = '0; end
      endcase
      // Both selected projections share a sign, so the values here are magnitudes.
      t1 = t1_s[TIME_W-1:0];
      t2 = t2_s[TIME_W-1:0];
      both = ACT_W'(t1) + ACT_W'(t2);
      diff = FULL_SCALE - $signed({2'b00, both});
      time_in.t0 = diff[ACT_W+1] ? '0 : diff[ZERO_W-1:0];
      time_in.sector = in_word.sector;
      time_in.act_a = '0;
      time_in.act_b = '0;
      time_in.act_c = '0;
      // With no sector both times are zero, so every phase lands on half scale.
      unique case (in_word.sector)
         SECTOR_1: begin
            time_in.act_a = both; time_in.act_b = ACT_W'(t2);
         end
         SECTOR_2: begin
            time_in.act_a = ACT_W'(t1); time_in.act_b = both;
         end
         SECTOR_3: begin
            time_in.act_b = both; time_in.act_c = ACT_W'(t2);
         end
         SECTOR_4: begin
            time_in.act_b = ACT_W'(t1); time_in.act_c = both;
         end
         SECTOR_5: begin
            time_in.act_a = ACT_W'(t2); time_in.act_c = both;
         end
         SECTOR_6: begin
            time_in.act_a = both; time_in.act_c = ACT_W'(t1);
         end
         default: begin
            time_in.act_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      time_ff <= time_in;
   end

   assign out_valid = valid_ff;
   assign out_word = time_ff;

endmodule

// File: design/svpd_duty.sv
// Stage four: rounded, saturated phase duties into the output register.
module svpd_duty import svpd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  time_type in_word,
   output logic     out_valid,
   output rsp_type  out_word
);

   logic    valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   function automatic logic [DUTY_W-1:0] duty_of(input logic [ZERO_W-1:0] t0,
                                                 input logic [ACT_W-1:0] act);
      logic [ACT_W+2:0] d;
      logic [ACT_W:0]   q;
      d = ACT_W'(0) + (ACT_W+3)'(t0) + {2'b00, act, 1'b0} + (ACT_W+3)'(2);
      q = d[ACT_W+2:2];
      return (q > (ACT_W+1)'(DUTY_MAX)) ? DUTY_MAX : q[DUTY_W-1:0];
   endfunction

   always_comb begin
      rsp_in.duty_a = duty_of(in_word.t0, in_word.act_a);
      rsp_in.duty_b = duty_of(in_word.t0, in_word.act_b);
      rsp_in.duty_c = duty_of(in_word.t0, in_word.act_c);
      rsp_in.sector_number = in_word.sector;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_word = rsp_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the space vector PWM duty core: directed and random vectors.
module tb_top;
   import svpd_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;

   // Each accepted word leaves its predicted duties and the word itself here.
   rsp_type duty_expected[$];
   req_type vector_sent[$];

   int failures = 0;
   int vectors_checked = 0;
   int sender_idle_pct = 0;
   int sector_hits[7];
   int saturated_hits = 0;

   space_vector_pwm_duty_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // cos30 * alpha in half-LSB units, rounded to nearest with ties upward.
   function automatic longint cos30_scaled(input longint alpha);
      return (longint'(COS30_Q16) * alpha + 16384) >>> 15;
   endfunction

   // Quarter-LSB duty sum rounded to a duty word, clamped to 0 and full scale.
   function automatic logic [DUTY_W-1:0] duty_from_times(input longint t0, input longint act);
      longint d;
      d = t0 + 2 * act;
      if (d < 0) begin
         d = 0;
      end
      d = (d + 2) >>> 2;
      if (d > longint'(DUTY_MAX)) begin
         d = longint'(DUTY_MAX);
      end
      return d[DUTY_W-1:0];
   endfunction

   function automatic rsp_type predict_duty(input req_type w);
      longint al, be, c, p1, p2, p3;
      longint t0, t1, t2, aa, ab, ac;
      logic pos1, pos2, pos3;
      logic [SECTOR_W-1:0] sec;
      rsp_type r;
      al = longint'($signed(w.alpha));
      be = longint'($signed(w.beta));
      c = cos30_scaled(al);
      p1 = 2 * be;
      p2 = c - be;
      p3 = -c - be;
      pos1 = p1 > 0;
      pos2 = p2 > 0;
      pos3 = p3 > 0;
      t1 = 0;
      t2 = 0;
      aa = 0;
      ab = 0;
      ac = 0;
      if (pos1 && pos2 && !pos3) sec = SECTOR_1;
      else if (pos1 && !pos2 && !pos3) sec = SECTOR_2;
      else if (pos1 && !pos2 && pos3) sec = SECTOR_3;
      else if (!pos1 && !pos2 && pos3) sec = SECTOR_4;
      else if (!pos1 && pos2 && pos3) sec = SECTOR_5;
      else if (!pos1 && pos2 && !pos3) sec = SECTOR_6;
      else sec = SECTOR_NONE;

      if (sec == SECTOR_NONE) begin
         r.duty_a = DUTY_MAX >> 1;
         r.duty_b = DUTY_MAX >> 1;
         r.duty_c = DUTY_MAX >> 1;
         r.sector_number = SECTOR_NONE;
         return r;
      end

      case (sec)
         SECTOR_1: begin t1 = p2;  t2 = p1;  end
         SECTOR_2: begin t1 = -p3; t2 = -p2; end
         SECTOR_3: begin t1 = p1;  t2 = p3;  end
         SECTOR_4: begin t1 = -p2; t2 = -p1; end
         SECTOR_5: begin t1 = p3;  t2 = p2;  end
         default:  begin t1 = -p1; t2 = -p3; end
      endcase

      // Overmodulation leaves no zero time at all.
      t0 = 65536 - t1 - t2;
      if (t0 < 0) begin
         t0 = 0;
      end

      case (sec)
         SECTOR_1: begin aa = t1 + t2; ab = t2;      ac = 0;       end
         SECTOR_2: begin aa = t1;      ab = t1 + t2; ac = 0;       end
         SECTOR_3: begin aa = 0;       ab = t1 + t2; ac = t2;      end
         SECTOR_4: begin aa = 0;       ab = t1;      ac = t1 + t2; end
         SECTOR_5: begin aa = t2;      ab = 0;       ac = t1 + t2; end
         default:  begin aa = t1 + t2; ab = 0;       ac = t1;      end
      endcase

      r.duty_a = duty_from_times(t0, aa);
      r.duty_b = duty_from_times(t0, ab);
      r.duty_c = duty_from_times(t0, ac);
      r.sector_number = sec;
      return r;
   endfunction

   // Presents one word and returns at the edge that takes it; start stays high after.
   task automatic send_vector(input int a, input int b);
      req_type w;
      w.alpha = a[ALPHA_W-1:0];
      w.beta = b[ALPHA_W-1:0];
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      duty_expected.push_back(predict_duty(w));
      vector_sent.push_back(w);
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val,
                              input req_type stim);
      if (exp_val != act_val) begin
         failures++;
         $display("%0t: %s mismatch for alpha=%0d beta=%0d: expected %0d, actual %0d",
                  $time, name, $signed(stim.alpha), $signed(stim.beta), exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_word;
      req_type stim;
      if (!reset && rsp_valid) begin
         if (duty_expected.size() == 0) begin
            failures++;
            $display("%0t: unexpected word: expected none, actual a=%0d b=%0d c=%0d sector=%0d",
                     $time, rsp_word.duty_a, rsp_word.duty_b, rsp_word.duty_c,
                     rsp_word.sector_number);
         end else begin
            exp_word = duty_expected.pop_front();
            stim = vector_sent.pop_front();
            check_field("duty_a", exp_word.duty_a, rsp_word.duty_a, stim);
            check_field("duty_b", exp_word.duty_b, rsp_word.duty_b, stim);
            check_field("duty_c", exp_word.duty_c, rsp_word.duty_c, stim);
            check_field("sector_number", exp_word.sector_number, rsp_word.sector_number, stim);
            vectors_checked++;
            sector_hits[exp_word.sector_number]++;
            if (exp_word.duty_a == DUTY_MAX || exp_word.duty_b == DUTY_MAX ||
                exp_word.duty_c == DUTY_MAX) begin
               saturated_hits++;
            end
         end
      end
   end

   task automatic test_zero_and_tiny();
      send_vector(0, 0);
      send_vector(1, 0);
      send_vector(-1, 0);
      send_vector(0, 1);
      send_vector(0, -1);
   endtask

   // Full-scale corners; the four diagonal ones drive the sum of active times past full scale.
   task automatic test_extremes();
      send_vector(32767, 0);
      send_vector(-32768, 0);
      send_vector(0, 32767);
      send_vector(0, -32768);
      send_vector(32767, 32767);
      send_vector(-32768, -32768);
      send_vector(32767, -32768);
      send_vector(-32768, 32767);
   endtask

   task automatic test_sector_centers();
      send_vector(13856, 8000);
      send_vector(0, 16000);
      send_vector(-13856, 8000);
      send_vector(-13856, -8000);
      send_vector(0, -16000);
      send_vector(13856, -8000);
   endtask

   // Vectors that put one projection at exactly zero, on a sector border.
   task automatic test_sector_edges();
      send_vector(1000, int'(cos30_scaled(1000)));
      send_vector(1000, -int'(cos30_scaled(1000)));
      send_vector(-1000, int'(cos30_scaled(-1000)));
      send_vector(-1000, -int'(cos30_scaled(-1000)));
      send_vector(18918, int'(cos30_scaled(18918)));
   endtask

   task automatic test_random_vectors(input int count, input int idle_pct);
      int a, b, mode;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         case (mode)
            0, 1, 2: begin
               a = int'($urandom_range(0, 65535)) - 32768;
               b = int'($urandom_range(0, 65535)) - 32768;
            end
            3, 4: begin
               a = int'($urandom_range(0, 46340)) - 23170;
               b = int'($urandom_range(0, 46340)) - 23170;
            end
            5: begin
               a = int'($urandom_range(0, 128)) - 64;
               b = int'($urandom_range(0, 128)) - 64;
            end
            6, 7: begin
               // Near a sector border: beta close to plus or minus cos30 * alpha in half-LSB units.
               a = int'($urandom_range(0, 37836)) - 18918;
               b = int'(cos30_scaled(a));
               if ($urandom_range(0, 1)) begin
                  b = -b;
               end
               b = b + int'($urandom_range(0, 4)) - 2;
               if (b > 32767) b = 32767;
               if (b < -32768) b = -32768;
            end
            default: begin
               a = int'($urandom_range(0, 65535)) - 32768;
               b = int'($urandom_range(0, 2)) - 1;
               if ($urandom_range(0, 1)) begin
                  mode = a;
                  a = b;
                  b = mode;
               end
            end
         endcase
         send_vector(a, b);
      end
   endtask

   task automatic drain_results();
      int waited;
      start <= 1'b0;
      waited = 0;
      while (duty_expected.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (duty_expected.size() != 0) begin
         failures++;
         $display("%0t: results missing: expected %0d more words, actual 0",
                  $time, duty_expected.size());
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 13;
      test_zero_and_tiny();
      test_extremes();
      test_sector_centers();
      test_sector_edges();
      test_random_vectors(550, 13);
      test_random_vectors(550, 70);
      test_random_vectors(550, 0);
      drain_results();

      $display("Checked %0d vectors; sectors 1..6 hit %0d/%0d/%0d/%0d/%0d/%0d times.",
               vectors_checked, sector_hits[1], sector_hits[2], sector_hits[3],
               sector_hits[4], sector_hits[5], sector_hits[6]);
      $display("Zero-vector results: %0d, results with a saturated duty: %0d.",
               sector_hits[0], saturated_hits);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/svpd_pkg.sv
design/svpd_proj.sv
design/svpd_time.sv
design/svpd_duty.sv
design/space_vector_pwm_duty_core.sv
tb/tb_top.sv
